FILE: sv/xss_pkg.sv
// Package for the settings scale scanner: parser phases, status codes,
// record kinds and the target name table. No dependencies.
package xss_pkg;

  typedef enum logic [3:0] {
    PH_ORDER, PH_HDRSKIP, PH_COUNT, PH_RECHDR, PH_NAME,
    PH_INTTAIL, PH_STRTAIL, PH_SKIP, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK, ST_HEADER, ST_TRUNC, ST_BAD_TYPE, ST_OVERFLOW
  } status_e;

  typedef enum logic [1:0] {
    KIND_INT, KIND_STR, KIND_COLOR, KIND_BAD
  } kind_e;

  localparam int unsigned TargetLen = 23;
  localparam int unsigned QueueDepth = 2;

  // One input item as it travels through the front-to-back queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_t;

  typedef struct packed {
    logic signed [31:0] scale;
    logic               changed;
    logic               found;
    logic [2:0]         status;
  } result_t;

  function automatic logic [7:0] target_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0: c = "G";   5'd1: c = "d";   5'd2: c = "k";   5'd3: c = "/";
      5'd4: c = "W";   5'd5: c = "i";   5'd6: c = "n";   5'd7: c = "d";
      5'd8: c = "o";   5'd9: c = "w";   5'd10: c = "S";  5'd11: c = "c";
      5'd12: c = "a";  5'd13: c = "l";  5'd14: c = "i";  5'd15: c = "n";
      5'd16: c = "g";  5'd17: c = "F";  5'd18: c = "a";  5'd19: c = "c";
      5'd20: c = "t";  5'd21: c = "o";  5'd22: c = "r";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/xss_if.sv
// Valid/ready channel interfaces for input bytes and results.
// Depends on xss_pkg.
interface xss_in_if;
  logic          valid;
  logic          ready;
  xss_pkg::byte_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface xss_out_if;
  logic            valid;
  logic            ready;
  xss_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/xss_queue.sv
// Front stage: accepts input bytes into a short FIFO that feeds the parser.
// Depends on xss_pkg.
module xss_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  xss_pkg::byte_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output xss_pkg::byte_t out_data_o
);
  import xss_pkg::*;

  byte_t      mem_q [QueueDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'(QueueDepth));
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // Store on push
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: sv/xss_parser.sv
// Back stage: byte-serial settings parser with a registered result stage.
// Depends on xss_pkg.
module xss_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  xss_pkg::byte_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output xss_pkg::result_t out_data_o
);
  import xss_pkg::*;

  phase_e      phase_q, phase_d;
  logic        msb_q, msb_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] word_q, word_d;
  logic [31:0] left_q, left_d;
  kind_e       kind_q, kind_d;
  logic [15:0] nlen_q, nlen_d;
  logic [4:0]  npos_q, npos_d;
  logic        match_q, match_d;
  logic [31:0] scale_q, scale_d;
  status_e     stat_q, stat_d;
  logic        found_q, found_d;
  logic        chg_q, chg_d;
  logic        ovalid_q;
  result_t     odata_q, res;
  logic        take;
  logic [7:0]  b;
  logic [1:0]  k;
  logic [31:0] rem_m1, asm_w, skip_n;

  assign in_ready_o  = !ovalid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign b      = in_data_i.data_byte;
  assign rem_m1 = rem_q - 32'd1;

  // Next parser state for one byte
  always_comb begin
    phase_d = phase_q; msb_d = msb_q; rem_d = rem_q; word_d = word_q;
    left_d = left_q; kind_d = kind_q; nlen_d = nlen_q; npos_d = npos_q;
    match_d = match_q; scale_d = scale_q; stat_d = stat_q;
    found_d = found_q; chg_d = chg_q;
    k = 2'(~rem_q[1:0] + 2'd1);  // position within a 4-byte field
    asm_w = 32'd0;
    skip_n = 32'd0;
    // Assemble one byte of a 32-bit field at position k
    if (msb_q) asm_w = (k == 2'd0) ? {24'd0, b} : {word_q[23:0], b};
    else       asm_w = ((k == 2'd0) ? 32'd0 : word_q) | ({24'd0, b} << {k, 3'b000});
    case (phase_q)
      PH_ORDER: begin
        if (b > 8'd1) begin
          stat_d = ST_HEADER; phase_d = PH_DONE;
        end else begin
          msb_d = b[0]; phase_d = PH_HDRSKIP; rem_d = 32'd7;
        end
      end
      PH_HDRSKIP: begin
        rem_d = rem_m1;
        if (rem_m1 == 32'd0) begin
          phase_d = PH_COUNT; rem_d = 32'd4;
        end
      end
      PH_COUNT: begin
        word_d = asm_w; rem_d = rem_m1;
        if (rem_m1 == 32'd0) begin
          if (asm_w == 32'd0) phase_d = PH_DONE;
          else begin
            left_d = asm_w - 32'd1; phase_d = PH_RECHDR; rem_d = 32'd4;
          end
        end
      end
      PH_RECHDR: begin
        if (k == 2'd0) kind_d = (b <= 8'd2) ? kind_e'(b[1:0]) : KIND_BAD;
        else if (k == 2'd2) word_d = msb_q ? {24'd0, b} : {24'd0, b};
        else if (k == 2'd3) word_d = msb_q ? {word_q[23:0], b} : (word_q | {16'd0, b, 8'd0});
        rem_d = rem_m1;
        if (rem_m1 == 32'd0) begin
          if (kind_q == KIND_BAD) begin
            stat_d = ST_BAD_TYPE; phase_d = PH_DONE;
          end else begin
            nlen_d = word_d[15:0]; npos_d = 5'd0; match_d = 1'b1;
            phase_d = PH_NAME;
            rem_d = {14'd0, word_d[15:0] + 16'd3, 2'b00} >> 2 << 2;
            rem_d = {14'd0, 18'({2'b00, word_d[15:0]} + 18'd3) & 18'h3FFFC};
          end
        end
      end
      PH_NAME: begin
        if (npos_q <= 5'(TargetLen)) begin
          if ({11'd0, npos_q} < nlen_q) begin
            if (npos_q < 5'(TargetLen)) begin
              if (b != target_char(npos_q)) match_d = 1'b0;
            end else if (b != 8'd0) match_d = 1'b0;
          end
          npos_d = npos_q + 5'd1;
        end
        rem_d = rem_m1;
      end
      PH_INTTAIL, PH_STRTAIL: begin
        if (rem_q <= 32'd4) word_d = asm_w;
        rem_d = rem_m1;
        if (rem_m1 == 32'd0) begin
          if (phase_q == PH_INTTAIL) begin
            if (asm_w != scale_q) begin
              scale_d = asm_w; chg_d = 1'b1;
            end
            found_d = 1'b1; phase_d = PH_DONE;
          end else if (asm_w > 32'hFFFF_FFFC) begin
            stat_d = ST_OVERFLOW; phase_d = PH_DONE;
          end else begin
            skip_n = (asm_w + 32'd3) & ~32'd3;
          end
        end
      end
      PH_SKIP: rem_d = rem_m1;
      default: ;
    endcase
    // End of name field (from record header with empty name, or last name byte)
    if ((phase_q == PH_NAME && rem_m1 == 32'd0) ||
        (phase_q == PH_RECHDR && rem_m1 == 32'd0 && kind_q != KIND_BAD &&
         word_d[15:0] == 16'd0)) begin
      if (kind_q == KIND_INT) begin
        if (match_d && nlen_d >= 16'(TargetLen)) begin
          phase_d = PH_INTTAIL; rem_d = 32'd8;
        end else skip_n = 32'd8;
      end else if (kind_q == KIND_COLOR) skip_n = 32'd12;
      else begin
        phase_d = PH_STRTAIL; rem_d = 32'd8;
      end
    end
    // Skip a run of bytes, or start the next record
    if (skip_n != 32'd0) begin
      phase_d = PH_SKIP; rem_d = skip_n;
    end else if ((phase_q == PH_SKIP && rem_m1 == 32'd0) ||
                 (phase_q == PH_STRTAIL && rem_m1 == 32'd0 && phase_d != PH_DONE)) begin
      if (left_q == 32'd0) phase_d = PH_DONE;
      else begin
        left_d = left_q - 32'd1; phase_d = PH_RECHDR; rem_d = 32'd4;
      end
    end
    // Form the result
    res.scale   = scale_d;
    res.changed = chg_d;
    res.found   = found_d;
    if (phase_d != PH_DONE)
      res.status = (phase_d <= PH_COUNT) ? ST_HEADER : ST_TRUNC;
    else res.status = stat_d;
  end

  // Hold parser state; clear per-blob state at the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ORDER; msb_q <= 1'b0; rem_q <= '0; word_q <= '0;
      left_q <= '0; kind_q <= KIND_INT; nlen_q <= '0; npos_q <= '0;
      match_q <= 1'b1; scale_q <= 32'd1; stat_q <= ST_OK;
      found_q <= 1'b0; chg_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (out_ready_i) ovalid_q <= 1'b0;
      if (take) begin
        scale_q <= scale_d;
        if (in_data_i.last_byte) begin
          phase_q <= PH_ORDER; msb_q <= 1'b0; rem_q <= '0; word_q <= '0;
          left_q <= '0; kind_q <= KIND_INT; nlen_q <= '0; npos_q <= '0;
          match_q <= 1'b1; stat_q <= ST_OK; found_q <= 1'b0; chg_q <= 1'b0;
          ovalid_q <= 1'b1;
        end else begin
          phase_q <= phase_d; msb_q <= msb_d; rem_q <= rem_d; word_q <= word_d;
          left_q <= left_d; kind_q <= kind_d; nlen_q <= nlen_d; npos_q <= npos_d;
          match_q <= match_d; stat_q <= stat_d; found_q <= found_d; chg_q <= chg_d;
        end
      end
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (take && in_data_i.last_byte) odata_q <= res;
  end
endmodule

FILE: sv/xsettings_scale_scanner_top.sv
// Result path: with the queue empty, a last byte accepted at the input is stored in the queue
// memory, then taken by the parser, which registers the result and offers it on out_ch.
// Throughput: one byte per cycle, set by the single-byte parser step, while a held result does not stall the parser.
// Reset: asynchronous active low; the kept scale resets to 1, the queue empties.
// Top level: byte queue in front of the settings parser.
// Depends on xss_pkg, xss_if, xss_queue and xss_parser.
module xsettings_scale_scanner_top (
  input  logic clk_i,
  input  logic rst_ni,
  xss_in_if.sink    in_ch,
  xss_out_if.source out_ch
);
  import xss_pkg::*;

  logic  q_valid, q_ready;
  byte_t q_data;

  xss_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid), .in_ready_o (in_ch.ready), .in_data_i (in_ch.payload),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  xss_parser u_parser (
    .clk_i, .rst_ni,
    .in_valid_i (q_valid), .in_ready_o (q_ready), .in_data_i (q_data),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_o(out_ch.payload)
  );
endmodule
